### hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants, types and the bit-serial modular step for the modular
// exponentiation core.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  localparam int WIDTH     = 32;
  localparam int TDATA_W   = ((WIDTH + 7) / 8) * 8;
  localparam int CNT_W     = $clog2(WIDTH);
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } state_t;

  // acc = (2*acc + bit_in*a) mod m, with acc, a < m and m in 1 .. 2^WIDTH
  function automatic logic [WIDTH-1:0] mod_step(input logic [WIDTH-1:0] acc,
                                                input logic [WIDTH-1:0] a,
                                                input logic             bit_in,
                                                input logic [WIDTH:0]   m);
    logic [WIDTH+1:0] s;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;
    logic [WIDTH+1:0] d;
    s  = {1'b0, acc, 1'b0} + (bit_in ? {2'b00, a} : '0);
    m1 = {1'b0, m};
    m2 = {m, 1'b0};
    if (s >= m2) begin
      d = s - m2;
    end else if (s >= m1) begin
      d = s - m1;
    end else begin
      d = s;
    end
    return d[WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// base^exponent mod modulus by left-to-right square-and-multiply, each
// modular product formed one multiplier bit per cycle.
// ----------------------------------------------------------------------------
//  channel   direction  tdata / data (low bit up)   handshake
//  s_axis    in         base                        s_axis_tvalid/tready
//  m_axis    out        result                      m_axis_tvalid/tready
//  cfg       in         cfg_index, cfg_data         cfg_valid/cfg_ready
//
//  One word takes a base reduction, then WIDTH squarings plus one multiply
//  per set exponent bit, each in the shared bit-serial multiplier; a zero
//  exponent or zero base goes straight to the finish state.
//  rst is synchronous; modulus resets to 1, exponent to 0.
//  A finished result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_core (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [mexp_pkg::TDATA_W-1:0]         s_axis_tdata,   // base
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [mexp_pkg::TDATA_W-1:0]         m_axis_tdata,   // result
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [mexp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [mexp_pkg::WIDTH-1:0]           cfg_data
);

  localparam int W = mexp_pkg::WIDTH;

  mexp_pkg::state_t state, state_next;

  logic [W-1:0]                modulus;
  logic [W-1:0]                exponent;
  logic [W:0]                  mod_ext;
  logic [W-1:0]                exp_sh;
  logic [W-1:0]                mpl;
  logic [W-1:0]                a_op;
  logic [W-1:0]                acc;
  logic [W-1:0]                rval;
  logic [W-1:0]                bval;
  logic [mexp_pkg::CNT_W-1:0]  cnt;
  logic [mexp_pkg::CNT_W-1:0]  ecnt;
  logic [W-1:0]                result;

  logic         in_acc;
  logic         load_out;
  logic         mul_last;
  logic         exp_last;
  logic [W-1:0] acc_next;
  logic [W-1:0] base;
  logic [W-1:0] one_mod;

  assign base      = s_axis_tdata[W-1:0];
  assign one_mod   = {{(W-1){1'b0}}, (modulus != {{(W-1){1'b0}}, 1'b1})};
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign mul_last  = (cnt == mexp_pkg::CNT_W'(W - 1));
  assign exp_last  = (ecnt == mexp_pkg::CNT_W'(W - 1));
  assign acc_next  = mexp_pkg::mod_step(acc, a_op, mpl[W-1], mod_ext);
  assign cfg_ready = 1'b1;
  assign m_axis_tdata = mexp_pkg::TDATA_W'(result);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mexp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (exponent == '0 || base == '0) begin
            state_next = mexp_pkg::ST_FINISH;
          end else begin
            state_next = mexp_pkg::ST_REDUCE;
          end
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (mul_last) state_next = mexp_pkg::ST_SQUARE;
      end
      mexp_pkg::ST_SQUARE: begin
        if (mul_last) begin
          priority if (exp_sh[W-1]) state_next = mexp_pkg::ST_MULT;
          else if (exp_last)        state_next = mexp_pkg::ST_FINISH;
          else                      state_next = mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_MULT: begin
        if (mul_last) begin
          if (exp_last) state_next = mexp_pkg::ST_FINISH;
          else          state_next = mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (load_out) state_next = mexp_pkg::ST_IDLE;
      end
      default: state_next = mexp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state == mexp_pkg::ST_IDLE);
    load_out      = (state == mexp_pkg::ST_FINISH) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mexp_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
      modulus       <= {{(W-1){1'b0}}, 1'b1};
      exponent      <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mexp_pkg::REG_MODULUS)  modulus  <= cfg_data;
        if (cfg_index == mexp_pkg::REG_EXPONENT) exponent <= cfg_data;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (load_out) result <= rval;
    unique case (state)
      mexp_pkg::ST_IDLE: begin
        mod_ext <= {(modulus == '0), modulus};
        exp_sh  <= exponent;
        acc     <= '0;
        cnt     <= '0;
        ecnt    <= '0;
        a_op    <= one_mod;
        mpl     <= base;
        if (exponent == '0) begin
          rval <= {{(W-1){1'b0}}, 1'b1};
        end else begin
          rval <= '0;
        end
      end
      mexp_pkg::ST_REDUCE, mexp_pkg::ST_SQUARE, mexp_pkg::ST_MULT: begin
        if (!mul_last) begin
          acc <= acc_next;
          mpl <= {mpl[W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
        end else begin
          acc <= '0;
          cnt <= '0;
          if (state == mexp_pkg::ST_REDUCE) begin
            bval <= acc_next;
            rval <= one_mod;
            a_op <= one_mod;
            mpl  <= one_mod;
          end else begin
            rval <= acc_next;
            a_op <= acc_next;
            if (state == mexp_pkg::ST_SQUARE && exp_sh[W-1]) begin
              mpl <= bval;
            end else begin
              mpl    <= acc_next;
              exp_sh <= {exp_sh[W-2:0], 1'b0};
              ecnt   <= ecnt + 1'b1;
            end
          end
        end
      end
      mexp_pkg::ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks for the modular exponentiation core.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_checker (
  input wire                                  clk,
  input wire                                  rst,
  input wire                                  s_axis_tvalid,
  input wire                                  s_axis_tready,
  input wire                                  m_axis_tvalid,
  input wire                                  m_axis_tready,
  input wire [mexp_pkg::TDATA_W-1:0]          m_axis_tdata
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed under stall");

  // one word in flight: no accept right after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // a result appears only after the core was busy
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without work");

  // after reset the core is idle with no result pending
  a_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> s_axis_tready && !m_axis_tvalid)
    else $error("bad state after reset");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/tb_modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_core
// Self-checking bench for the modular exponentiation core. A directed table
// covers reset values, zero exponent and zero base, modulus of one, bases at
// or above the modulus, and the extreme operand values. Random phases with
// fresh modulus and exponent settings follow. Input words arrive in bursts,
// and the output side stalls in changing patterns. Each result is compared
// in order against a table value or a square-and-multiply predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_modular_exponentiation_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W             = mexp_pkg::WIDTH;
  localparam int N_DIRECTED    = 20;
  localparam int N_PHASES      = 10;
  localparam int PHASE_WORDS   = 27;
  localparam int SETTLE_CYCLES = W * (2 * W + 1) + 2 + 64;

  typedef struct packed {
    logic         do_cfg;
    logic [W-1:0] modulus;
    logic [W-1:0] exponent;
    logic [W-1:0] base;
    logic         known;
    logic [W-1:0] value;
  } dir_row_t;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678, 1'b1, 32'h0000_0001},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{1'b1, 32'd497,       32'd13,        32'd4,         1'b1, 32'd445},
    '{1'b0, 32'd497,       32'd13,        32'd0,         1'b1, 32'd0},
    '{1'b0, 32'd497,       32'd13,        32'd497,       1'b1, 32'd0},
    '{1'b0, 32'd497,       32'd13,        32'hFFFF_FFFF, 1'b0, 32'd0},
    '{1'b1, 32'd1,         32'd0,         32'd5,         1'b1, 32'd1},
    '{1'b1, 32'd1,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'd0},
    '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
    '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,         1'b1, 32'd1},
    '{1'b1, 32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'd2,         1'b0, 32'd0},
    '{1'b1, 32'h8000_0000, 32'd1,         32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{1'b1, 32'd2,         32'h8000_0000, 32'd3,         1'b0, 32'd0},
    '{1'b1, 32'hFFFF_FFFF, 32'd0,         32'd0,         1'b1, 32'd1},
    '{1'b1, 32'd3233,      32'd17,        32'd65,        1'b1, 32'd2790},
    '{1'b1, 32'd3233,      32'd413,       32'd2790,      1'b1, 32'd65},
    '{1'b1, 32'h0001_0001, 32'd2,         32'hFFFF_FFFF, 1'b0, 32'd0},
    '{1'b1, 32'hFFFF_FFFF, 32'd1,         32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA},
    '{1'b0, 32'hFFFF_FFFF, 32'd1,         32'h5555_5555, 1'b0, 32'd0}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic [mexp_pkg::TDATA_W-1:0]   s_tdata = '0;
  logic                           s_axis_tready;
  logic                           m_axis_tvalid;
  logic                           m_tready = 1'b0;
  logic [mexp_pkg::TDATA_W-1:0]   m_axis_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [W-1:0]                   cfg_data = '0;

  logic [W-1:0] cur_modulus  = 1;
  logic [W-1:0] cur_exponent = 0;
  logic [W-1:0] expected_results [$];
  int           burst_left = 0;
  int           words_sent = 0;
  int           results_seen = 0;
  int           reg_writes = 0;
  int           fail_count = 0;

  modular_exponentiation_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("modular_exponentiation_core test failed");
    $finish;
  end

  // modulus of zero stands for 2^W
  function automatic logic [W-1:0] power_mod(input logic [W-1:0] b,
                                             input logic [W-1:0] m,
                                             input logic [W-1:0] e);
    logic [2*W-1:0] r;
    logic [2*W-1:0] x;
    logic [2*W-1:0] mm;
    if (e == '0) return W'(1);
    if (b == '0) return '0;
    mm = {{W{1'b0}}, m};
    if (m == '0) mm = {{(W-1){1'b0}}, 1'b1, {W{1'b0}}};
    x  = {{W{1'b0}}, b} % mm;
    r  = {{(2*W-1){1'b0}}, (m != W'(1))};
    for (int i = W - 1; i >= 0; i--) begin
      r = (r * r) % mm;
      if (e[i]) r = (r * x) % mm;
    end
    return r[W-1:0];
  endfunction

  task automatic send_base(input logic [W-1:0] b, input logic [W-1:0] want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= mexp_pkg::TDATA_W'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= mexp_pkg::TDATA_W'(b);
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(want);
    words_sent++;
    burst_left--;
  endtask

  // registers change only with the core empty
  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [mexp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == mexp_pkg::REG_MODULUS) cur_modulus = data;
    else if (idx == mexp_pkg::REG_EXPONENT) cur_exponent = data;
    reg_writes++;
  endtask

  // output side: free-running, random, or long stalls, in a mode redrawn periodically
  initial begin
    int mode;
    int stall_left;
    int cyc;
    logic [W-1:0] want;
    mode = 0;
    stall_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result word %h", m_axis_tdata[W-1:0]);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[W-1:0] !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: result %0d expected %h got %h", results_seen, want,
                       m_axis_tdata[W-1:0]);
          end
        end
      end
      cyc++;
      if (cyc % 300 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(10, 40);
          end
        end
      endcase
    end
  end

  initial begin
    logic [W-1:0] mod_v;
    logic [W-1:0] exp_v;
    logic [W-1:0] b;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (dir_rows[i].do_cfg) begin
        drain();
        cfg_write(mexp_pkg::REG_MODULUS, dir_rows[i].modulus);
        cfg_write(mexp_pkg::REG_EXPONENT, dir_rows[i].exponent);
        cfg_valid <= 1'b0;
      end
      send_base(dir_rows[i].base, dir_rows[i].known ? dir_rows[i].value :
                power_mod(dir_rows[i].base, cur_modulus, cur_exponent));
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: mod_v = $urandom;
        1: mod_v = $urandom_range(1, 300);
        2: mod_v = 1;
        3: mod_v = '1;
        4: mod_v = W'(1) << $urandom_range(0, W - 1);
        default: mod_v = $urandom | 32'h8000_0001;
      endcase
      if (mod_v == 0) mod_v = 1;
      case ($urandom_range(0, 5))
        0: exp_v = $urandom;
        1: exp_v = 0;
        2: exp_v = $urandom_range(1, 16);
        3: exp_v = '1;
        4: exp_v = 65537;
        default: exp_v = W'(1) << $urandom_range(0, W - 1);
      endcase
      drain();
      // an unused index must leave both registers alone
      cfg_write(mexp_pkg::CFG_IDX_W'($urandom_range(2, 255)), $urandom);
      if ($urandom_range(0, 1)) begin
        cfg_write(mexp_pkg::REG_MODULUS, mod_v);
        cfg_write(mexp_pkg::REG_EXPONENT, exp_v);
      end else begin
        cfg_write(mexp_pkg::REG_EXPONENT, exp_v);
        cfg_write(mexp_pkg::REG_MODULUS, mod_v);
      end
      cfg_valid <= 1'b0;
      for (int j = 0; j < PHASE_WORDS; j++) begin
        case ($urandom_range(0, 9))
          0: b = 0;
          1: b = '1;
          2: b = cur_modulus;
          3: b = cur_modulus - 1;
          4: b = $urandom_range(1, 5);
          default: b = $urandom;
        endcase
        send_base(b, power_mod(b, cur_modulus, cur_exponent));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d directed and %0d random words under %0d register writes,",
             N_DIRECTED, words_sent - N_DIRECTED, reg_writes);
    $display("%0d result words checked, %0d failures.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("modular_exponentiation_core test passed");
    end else begin
      $display("modular_exponentiation_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### modular_exponentiation_core.f
hdl/mexp_pkg.sv
hdl/modular_exponentiation_core.sv
hdl/mexp_checker.sv
tb/tb_modular_exponentiation_core.sv
